// ===== hdl/hbs_pkg.sv =====
// Shared constants, codes and types of the heightmap bilinear sampler.
package hbs_pkg;

   localparam int MAX_DIM     = 256;
   localparam int FRAC_BITS   = 16;
   localparam int DATA_BITS   = 32;
   localparam int IDX_BITS    = $clog2(MAX_DIM);
   localparam int DIM_BITS    = $clog2(MAX_DIM + 1);
   localparam int ADDR_BITS   = 2 * IDX_BITS;
   localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
   localparam int MUL_BITS    = 2 * DATA_BITS;
   localparam int CELL_BITS   = MUL_BITS - 2 * FRAC_BITS;
   localparam int LERP_BITS   = DATA_BITS + FRAC_BITS + 2;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] OP_WRITE_CELL = 2'd0;
   localparam logic [1:0] OP_READ_CELL  = 2'd1;
   localparam logic [1:0] OP_WRITE_POS  = 2'd2;
   localparam logic [1:0] OP_SAMPLE     = 2'd3;

   typedef struct packed {
      logic [DATA_BITS-1:0] origin_x;
      logic [DATA_BITS-1:0] origin_z;
      logic [DATA_BITS-1:0] cpu_x;
      logic [DATA_BITS-1:0] cpu_z;
      logic [DIM_BITS-1:0]  width;
      logic [DIM_BITS-1:0]  height;
   } cfg_type;

   typedef struct packed {
      logic [1:0]           opcode;
      logic                 ok;
      logic [IDX_BITS-1:0]  col;
      logic [IDX_BITS-1:0]  row;
      logic [FRAC_BITS-1:0] tx;
      logic [FRAC_BITS-1:0] tz;
      logic [DATA_BITS-1:0] value;
   } entry_type;

   typedef struct packed {
      logic [QCNT_BITS-1:0] count;
      logic                 empty;
   } qstat_type;

endpackage

// ===== hdl/hbs_front.sv =====
// Front end: takes request words, maps positions to cells and checks the grid bounds.
module hbs_front import hbs_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  cfg_type              cfg,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           opcode,
   input  logic [DATA_BITS-1:0] pos_x,
   input  logic [DATA_BITS-1:0] pos_z,
   input  logic [7:0]           col_index,
   input  logic [7:0]           row_index,
   input  logic [DATA_BITS-1:0] height_value,
   input  qstat_type            qstat,
   output logic                 push,
   output entry_type            push_entry
);

   logic                 s1_valid_ff, s1_valid_in;
   logic [1:0]           s1_op_ff;
   logic [7:0]           s1_col_ff, s1_row_ff;
   logic [DATA_BITS-1:0] s1_val_ff;
   logic [DATA_BITS:0]   s1_dx_ff, s1_dz_ff, dx_in, dz_in;

   logic                 s2_valid_ff, s2_valid_in;
   logic [1:0]           s2_op_ff;
   logic [7:0]           s2_col_ff, s2_row_ff;
   logic [DATA_BITS-1:0] s2_val_ff;
   logic                 s2_negx_ff, s2_negz_ff;
   logic [MUL_BITS-1:0]  s2_px_ff, s2_pz_ff, px_in, pz_in;

   logic [QCNT_BITS:0]   occupancy;
   logic                 accept;
   logic                 is_pos, loc_ok, fits, next_fits;
   logic [CELL_BITS-1:0] col_full, row_full;

   // Every word in flight holds a queue slot, so a push never meets a full queue.
   assign occupancy = (QCNT_BITS+1)'(qstat.count) + (QCNT_BITS+1)'(s1_valid_ff)
                    + (QCNT_BITS+1)'(s2_valid_ff);
   assign req_ready = occupancy < (QCNT_BITS+1)'(QUEUE_DEPTH);
   assign accept    = req_valid && req_ready;

   assign dx_in = {pos_x[DATA_BITS-1], pos_x} - {cfg.origin_x[DATA_BITS-1], cfg.origin_x};
   assign dz_in = {pos_z[DATA_BITS-1], pos_z} - {cfg.origin_z[DATA_BITS-1], cfg.origin_z};
   assign px_in = MUL_BITS'(s1_dx_ff[DATA_BITS-1:0]) * MUL_BITS'(cfg.cpu_x);
   assign pz_in = MUL_BITS'(s1_dz_ff[DATA_BITS-1:0]) * MUL_BITS'(cfg.cpu_z);

   assign s1_valid_in = accept;
   assign s2_valid_in = s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff  <= opcode;
         s1_col_ff <= col_index;
         s1_row_ff <= row_index;
         s1_val_ff <= height_value;
         s1_dx_ff  <= dx_in;
         s1_dz_ff  <= dz_in;
      end
      s2_op_ff   <= s1_op_ff;
      s2_col_ff  <= s1_col_ff;
      s2_row_ff  <= s1_row_ff;
      s2_val_ff  <= s1_val_ff;
      s2_negx_ff <= s1_dx_ff[DATA_BITS];
      s2_negz_ff <= s1_dz_ff[DATA_BITS];
      s2_px_ff   <= px_in;
      s2_pz_ff   <= pz_in;
   end

   always_comb begin
      is_pos   = (s2_op_ff == OP_WRITE_POS) || (s2_op_ff == OP_SAMPLE);
      loc_ok   = !is_pos || (!s2_negx_ff && !s2_negz_ff);
      col_full = is_pos ? s2_px_ff[MUL_BITS-1:2*FRAC_BITS] : CELL_BITS'(s2_col_ff);
      row_full = is_pos ? s2_pz_ff[MUL_BITS-1:2*FRAC_BITS] : CELL_BITS'(s2_row_ff);
      fits     = (col_full < CELL_BITS'(cfg.width)) && (row_full < CELL_BITS'(cfg.height));
      // A sample also needs the neighbor cell to the right and below.
      next_fits = (({1'b0, col_full} + (CELL_BITS+1)'(1)) < (CELL_BITS+1)'(cfg.width))
               && (({1'b0, row_full} + (CELL_BITS+1)'(1)) < (CELL_BITS+1)'(cfg.height));

      push_entry.opcode = s2_op_ff;
      push_entry.ok     = loc_ok && fits && ((s2_op_ff != OP_SAMPLE) || next_fits);
      push_entry.col    = col_full[IDX_BITS-1:0];
      push_entry.row    = row_full[IDX_BITS-1:0];
      push_entry.tx     = s2_px_ff[2*FRAC_BITS-1:FRAC_BITS];
      push_entry.tz     = s2_pz_ff[2*FRAC_BITS-1:FRAC_BITS];
      push_entry.value  = s2_val_ff;
   end

   assign push = s2_valid_ff;

endmodule

// ===== hdl/hbs_queue.sv =====
// Short queue of classified commands between the front end and the back end.
module hbs_queue import hbs_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output entry_type head,
   output qstat_type qstat
);

   entry_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_BITS'(push) - QCNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head        = slot_ff[rd_ptr_ff];
   assign qstat.count = count_ff;
   assign qstat.empty = (count_ff == '0);

endmodule

// ===== hdl/hbs_back.sv =====
// Back end: height store, cell access sequencer, bilinear blend and the result register.
module hbs_back import hbs_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [DIM_BITS-1:0]  width,
   input  entry_type            head,
   input  qstat_type            qstat,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [DATA_BITS-1:0] height_out,
   output logic                 in_range
);

   localparam logic [2:0] B_IDLE   = 3'd0;
   localparam logic [2:0] B_EXEC   = 3'd1;
   localparam logic [2:0] B_RWAIT  = 3'd2;
   localparam logic [2:0] B_SREAD  = 3'd3;
   localparam logic [2:0] B_SDRAIN = 3'd4;
   localparam logic [2:0] B_SMUL   = 3'd5;
   localparam logic [2:0] B_SADD   = 3'd6;

   localparam logic [1:0] STEP_TOP    = 2'd0;
   localparam logic [1:0] STEP_BOTTOM = 2'd1;
   localparam logic [1:0] STEP_BLEND  = 2'd2;

   logic [DATA_BITS-1:0] store [STORE_DEPTH];

   logic [2:0]            state_ff, state_in;
   entry_type             cur_ff, cur_in;
   logic [1:0]            k_ff, k_in;
   logic [1:0]            step_ff, step_in;
   logic                  rd_pend_ff, rd_pend_in;
   logic [1:0]            rd_k_ff;
   logic [DATA_BITS-1:0]  rd_data_ff;
   logic [DATA_BITS-1:0]  h_ff [4];
   logic signed [LERP_BITS-1:0] prod_ff, prod_in;
   logic [DATA_BITS-1:0]  base_ff, base_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_BITS-1:0]  rsp_height_ff, rsp_height_in;
   logic                  rsp_range_ff, rsp_range_in;

   logic [IDX_BITS-1:0]   sel_col, sel_row;
   logic [ADDR_BITS-1:0]  row_base, addr;
   logic                  mem_we, mem_re;
   logic [DATA_BITS-1:0]  op_a, op_b, blend;
   logic [FRAC_BITS-1:0]  op_t;
   logic signed [DATA_BITS:0] diff;
   logic signed [FRAC_BITS:0] t_s;
   logic                  h_we;
   logic [1:0]            h_idx;

   // Corner order of a sample: bit 0 of k steps the column, bit 1 the row.
   assign sel_col  = cur_ff.col + IDX_BITS'(k_ff[0]);
   assign sel_row  = cur_ff.row + IDX_BITS'(k_ff[1]);
   assign row_base = ADDR_BITS'(sel_row) * ADDR_BITS'(width);
   assign addr     = row_base + ADDR_BITS'(sel_col);

   assign pop    = (state_ff == B_IDLE) && !qstat.empty && (!rsp_valid_ff || rsp_ready);
   assign mem_we = (state_ff == B_EXEC) && cur_ff.ok
                && ((cur_ff.opcode == OP_WRITE_CELL) || (cur_ff.opcode == OP_WRITE_POS));
   assign mem_re = ((state_ff == B_EXEC) && cur_ff.ok && (cur_ff.opcode == OP_READ_CELL))
                || (state_ff == B_SREAD);
   assign rd_pend_in = mem_re;

   always_comb begin
      case (step_ff)
         STEP_TOP: begin
            op_a = h_ff[0];
            op_b = h_ff[1];
            op_t = cur_ff.tx;
         end
         STEP_BOTTOM: begin
            op_a = h_ff[2];
            op_b = h_ff[3];
            op_t = cur_ff.tx;
         end
         default: begin
            op_a = h_ff[0];
            op_b = h_ff[2];
            op_t = cur_ff.tz;
         end
      endcase
      diff    = $signed({op_b[DATA_BITS-1], op_b} - {op_a[DATA_BITS-1], op_a});
      t_s     = $signed({1'b0, op_t});
      prod_in = LERP_BITS'(diff * t_s);
      base_in = op_a;
      // The arithmetic shift of the product floors it; the blend stays between its ends.
      blend   = base_ff + prod_ff[FRAC_BITS +: DATA_BITS];
   end

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      k_in          = k_ff;
      step_in       = step_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_height_in = rsp_height_ff;
      rsp_range_in  = rsp_range_ff;
      h_we          = 1'b0;
      h_idx         = 2'd0;
      case (state_ff)
         B_IDLE: begin
            if (pop) begin
               cur_in   = head;
               k_in     = 2'd0;
               state_in = B_EXEC;
            end
         end
         B_EXEC: begin
            if (!cur_ff.ok) begin
               rsp_valid_in  = 1'b1;
               rsp_height_in = '0;
               rsp_range_in  = 1'b0;
               state_in      = B_IDLE;
            end else begin
               case (cur_ff.opcode)
                  OP_READ_CELL: state_in = B_RWAIT;
                  OP_SAMPLE:    state_in = B_SREAD;
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_height_in = '0;
                     rsp_range_in  = 1'b1;
                     state_in      = B_IDLE;
                  end
               endcase
            end
         end
         B_RWAIT: begin
            rsp_valid_in  = 1'b1;
            rsp_height_in = rd_data_ff;
            rsp_range_in  = 1'b1;
            state_in      = B_IDLE;
         end
         B_SREAD: begin
            k_in = k_ff + 2'd1;
            if (&k_ff) begin
               state_in = B_SDRAIN;
            end
         end
         B_SDRAIN: begin
            step_in  = STEP_TOP;
            state_in = B_SMUL;
         end
         B_SMUL: begin
            state_in = B_SADD;
         end
         B_SADD: begin
            case (step_ff)
               STEP_TOP: begin
                  h_we     = 1'b1;
                  h_idx    = 2'd0;
                  step_in  = STEP_BOTTOM;
                  state_in = B_SMUL;
               end
               STEP_BOTTOM: begin
                  h_we     = 1'b1;
                  h_idx    = 2'd2;
                  step_in  = STEP_BLEND;
                  state_in = B_SMUL;
               end
               default: begin
                  rsp_valid_in  = 1'b1;
                  rsp_height_in = blend;
                  rsp_range_in  = 1'b1;
                  state_in      = B_IDLE;
               end
            endcase
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
         rd_pend_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_pend_ff   <= rd_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      k_ff          <= k_in;
      step_ff       <= step_in;
      rd_k_ff       <= k_ff;
      prod_ff       <= prod_in;
      base_ff       <= base_in;
      rsp_height_ff <= rsp_height_in;
      rsp_range_ff  <= rsp_range_in;
      if (rd_pend_ff) begin
         h_ff[rd_k_ff] <= rd_data_ff;
      end else if (h_we) begin
         h_ff[h_idx] <= blend;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store[addr] <= cur_ff.value;
      end
      if (mem_re) begin
         rd_data_ff <= store[addr];
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign height_out = rsp_height_ff;
   assign in_range   = rsp_range_ff;

endmodule

// ===== hdl/heightmap_bilinear_sampler.sv =====
// Top level of the heightmap bilinear sampler: register file, front end, queue and back end.
//
//   Channel  Ports      Word
//   request  req_*      tuser: opcode; tdata: pos_x, pos_z, col_index, row_index, height_value
//   result   rsp_*      tuser: in_range; tdata: height_out
//   control  csr_*      registers at byte address 4*i, 32-bit data
//
// The front end takes a word, subtracts the origin into the s1 registers and multiplies by the
// cell scale into the s2 registers, then classifies it into a four-entry queue.
// The back end, built around a single-port store, takes the next word only from B_IDLE;
// a write passes B_EXEC, a read B_EXEC and B_RWAIT, and a sample makes four store reads, then
// three blends through one shared multiplier. A word outside the grid ends in B_EXEC, whatever its opcode.
// Reset is synchronous and clears control state; the store holds nothing defined until written.
// A stalled result holds in its register while the front end keeps filling the queue.
module heightmap_bilinear_sampler import hbs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [111:0] req_tdata,  // pos_x, pos_z, col_index, row_index, height_value
   input  logic [1:0]   req_tuser,  // opcode
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,  // height_out
   output logic [0:0]   rsp_tuser,  // in_range
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam logic [2:0] REG_ORIGIN_X    = 3'd0;
   localparam logic [2:0] REG_ORIGIN_Z    = 3'd1;
   localparam logic [2:0] REG_CPU_X       = 3'd2;
   localparam logic [2:0] REG_CPU_Z       = 3'd3;
   localparam logic [2:0] REG_GRID_WIDTH  = 3'd4;
   localparam logic [2:0] REG_GRID_HEIGHT = 3'd5;

   logic [31:0] origin_x_ff, origin_z_ff, cpu_x_ff, cpu_z_ff;
   logic [8:0]  grid_width_ff, grid_height_ff;
   logic        csr_write;
   logic [2:0]  csr_index;

   cfg_type     cfg;
   entry_type   push_entry, head;
   qstat_type   qstat;
   logic        q_push, q_pop;
   logic [DATA_BITS-1:0] height_out;
   logic        in_range;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff    <= '0;
         origin_z_ff    <= '0;
         cpu_x_ff       <= 32'(1) << FRAC_BITS;
         cpu_z_ff       <= 32'(1) << FRAC_BITS;
         grid_width_ff  <= 9'd256;
         grid_height_ff <= 9'd256;
      end else if (csr_write) begin
         case (csr_index)
            REG_ORIGIN_X:    origin_x_ff    <= csr_pwdata;
            REG_ORIGIN_Z:    origin_z_ff    <= csr_pwdata;
            REG_CPU_X:       cpu_x_ff       <= csr_pwdata;
            REG_CPU_Z:       cpu_z_ff       <= csr_pwdata;
            REG_GRID_WIDTH:  grid_width_ff  <= csr_pwdata[8:0];
            REG_GRID_HEIGHT: grid_height_ff <= csr_pwdata[8:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_ORIGIN_X:    csr_prdata = origin_x_ff;
         REG_ORIGIN_Z:    csr_prdata = origin_z_ff;
         REG_CPU_X:       csr_prdata = cpu_x_ff;
         REG_CPU_Z:       csr_prdata = cpu_z_ff;
         REG_GRID_WIDTH:  csr_prdata = 32'(grid_width_ff);
         REG_GRID_HEIGHT: csr_prdata = 32'(grid_height_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // A grid size of zero acts as one, and one above the store's side acts as that side.
   always_comb begin
      cfg.origin_x = origin_x_ff;
      cfg.origin_z = origin_z_ff;
      cfg.cpu_x    = cpu_x_ff;
      cfg.cpu_z    = cpu_z_ff;
      if (grid_width_ff == '0) begin
         cfg.width = DIM_BITS'(1);
      end else if (int'(grid_width_ff) > MAX_DIM) begin
         cfg.width = DIM_BITS'(MAX_DIM);
      end else begin
         cfg.width = DIM_BITS'(grid_width_ff);
      end
      if (grid_height_ff == '0) begin
         cfg.height = DIM_BITS'(1);
      end else if (int'(grid_height_ff) > MAX_DIM) begin
         cfg.height = DIM_BITS'(MAX_DIM);
      end else begin
         cfg.height = DIM_BITS'(grid_height_ff);
      end
   end

   hbs_front u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .opcode       (req_tuser),
      .pos_x        (req_tdata[31:0]),
      .pos_z        (req_tdata[63:32]),
      .col_index    (req_tdata[71:64]),
      .row_index    (req_tdata[79:72]),
      .height_value (req_tdata[111:80]),
      .qstat        (qstat),
      .push         (q_push),
      .push_entry   (push_entry)
   );

   hbs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .head       (head),
      .qstat      (qstat)
   );

   hbs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .width      (cfg.width),
      .head       (head),
      .qstat      (qstat),
      .pop        (q_pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .height_out (height_out),
      .in_range   (in_range)
   );

   assign rsp_tdata    = height_out;
   assign rsp_tuser[0] = in_range;

`ifndef SYNTHESIS
   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (qstat.count < QCNT_BITS'(QUEUE_DEPTH)))
      else $error("command pushed into a full queue");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !qstat.empty)
      else $error("command popped from an empty queue");

   a_result_slot_free: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (!rsp_tvalid || rsp_tready))
      else $error("command started while the result register is still occupied");

   a_outside_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata == '0))
      else $error("result outside the grid carries a nonzero height");
`endif

endmodule

// ===== dv/tb_heightmap_bilinear_sampler.sv =====
// Self-checking testbench for the heightmap bilinear sampler: directed words, then random phases.
`timescale 1ns / 100ps

module tb_heightmap_bilinear_sampler;
   import hbs_pkg::*;

   localparam int REG_ORIGIN_X    = 0;
   localparam int REG_ORIGIN_Z    = 1;
   localparam int REG_CELLS_X     = 2;
   localparam int REG_CELLS_Z     = 3;
   localparam int REG_GRID_WIDTH  = 4;
   localparam int REG_GRID_HEIGHT = 5;
   localparam int NUM_DIRECTED    = 25;
   localparam int NUM_FIXED       = 5;
   localparam int NUM_RANDOM_GRID = 6;
   localparam int CYCLE_LIMIT     = 400000;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] pos_x;
      logic [31:0] pos_z;
      logic [7:0]  col;
      logic [7:0]  row;
      logic [31:0] value;
      logic        typed;
      logic [31:0] want_height;
      logic        want_range;
   } stim_row_type;

   typedef struct packed {
      logic [31:0] height;
      logic        in_range;
   } height_answer_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [111:0] req_tdata = '0;  // pos_x, pos_z, col_index, row_index, height_value
   logic [1:0]   req_tuser = '0;  // opcode
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [31:0]  rsp_tdata;       // height_out
   logic [0:0]   rsp_tuser;       // in_range
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [4:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   heightmap_bilinear_sampler u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Shadow of the block: register values and the height store with a written flag per cell.
   cfg_type           grid_now = '{32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 9'd256, 9'd256};
   logic [31:0]       store_copy [0:STORE_DEPTH-1];
   bit                written_map [0:STORE_DEPTH-1];
   height_answer_type pending_heights [$];

   int  mismatch_count = 0;
   int  checked_count  = 0;
   int  cycle_count    = 0;
   int  settings_count = 0;
   int  op_count [4]   = '{0, 0, 0, 0};
   int  sample_hits    = 0;
   bit  calm_stretch   = 1'b0;

   stim_row_type directed_rows [0:NUM_DIRECTED-1] = '{
      '{OP_WRITE_CELL, 32'h0, 32'h0, 8'd0, 8'd0, 32'h7FFF_FFFF, 1'b1, 32'h0, 1'b1},
      '{OP_WRITE_CELL, 32'h0, 32'h0, 8'd1, 8'd0, 32'h8000_0000, 1'b1, 32'h0, 1'b1},
      '{OP_WRITE_CELL, 32'h0, 32'h0, 8'd0, 8'd1, 32'h0001_0000, 1'b1, 32'h0, 1'b1},
      '{OP_WRITE_CELL, 32'h0, 32'h0, 8'd1, 8'd1, 32'hFFFF_0000, 1'b1, 32'h0, 1'b1},
      '{OP_READ_CELL,  32'h0, 32'h0, 8'd0, 8'd0, 32'h0, 1'b1, 32'h7FFF_FFFF, 1'b1},
      '{OP_READ_CELL,  32'h0, 32'h0, 8'd1, 8'd0, 32'h0, 1'b1, 32'h8000_0000, 1'b1},
      '{OP_READ_CELL,  32'h0, 32'h0, 8'd0, 8'd1, 32'h0, 1'b1, 32'h0001_0000, 1'b1},
      '{OP_READ_CELL,  32'h0, 32'h0, 8'd1, 8'd1, 32'h0, 1'b1, 32'hFFFF_0000, 1'b1},
      '{OP_WRITE_CELL, 32'h0, 32'h0, 8'd255, 8'd255, 32'hA5A5_5A5A, 1'b1, 32'h0, 1'b1},
      '{OP_READ_CELL,  32'h0, 32'h0, 8'd255, 8'd255, 32'h0, 1'b1, 32'hA5A5_5A5A, 1'b1},
      '{OP_SAMPLE, 32'h0, 32'h0, 8'd0, 8'd0, 32'h0, 1'b1, 32'h7FFF_FFFF, 1'b1},
      '{OP_SAMPLE, 32'h0000_8000, 32'h0000_8000, 8'd0, 8'd0, 32'h0, 1'b0, 32'h0, 1'b0},
      '{OP_SAMPLE, 32'h0000_FFFF, 32'h0000_FFFF, 8'd0, 8'd0, 32'h0, 1'b0, 32'h0, 1'b0},
      '{OP_SAMPLE, 32'h0000_4000, 32'h0000_C000, 8'd0, 8'd0, 32'h0, 1'b0, 32'h0, 1'b0},
      '{OP_SAMPLE, 32'h00FF_0000, 32'h0, 8'd0, 8'd0, 32'h0, 1'b1, 32'h0, 1'b0},
      '{OP_SAMPLE, 32'h0, 32'h00FF_8000, 8'd0, 8'd0, 32'h0, 1'b1, 32'h0, 1'b0},
      '{OP_SAMPLE, 32'hFFFF_FFFF, 32'h0, 8'd0, 8'd0, 32'h0, 1'b1, 32'h0, 1'b0},
      '{OP_SAMPLE, 32'h7FFF_FFFF, 32'h0, 8'd0, 8'd0, 32'h0, 1'b1, 32'h0, 1'b0},
      '{OP_SAMPLE, 32'h0, 32'h8000_0000, 8'd0, 8'd0, 32'h0, 1'b1, 32'h0, 1'b0},
      '{OP_WRITE_POS, 32'h0001_8000, 32'h0, 8'd0, 8'd0, 32'h0002_0000, 1'b1, 32'h0, 1'b1},
      '{OP_READ_CELL, 32'h0, 32'h0, 8'd1, 8'd0, 32'h0, 1'b1, 32'h0002_0000, 1'b1},
      '{OP_WRITE_POS, 32'h8000_0000, 32'h0, 8'd0, 8'd0, 32'h1234_5678, 1'b1, 32'h0, 1'b0},
      '{OP_WRITE_POS, 32'h0100_0000, 32'h0, 8'd0, 8'd0, 32'h1234_5678, 1'b1, 32'h0, 1'b0},
      '{OP_WRITE_CELL, 32'h0, 32'h0, 8'd200, 8'd7, 32'h0, 1'b1, 32'h0, 1'b1},
      '{OP_READ_CELL,  32'h0, 32'h0, 8'd200, 8'd7, 32'h0, 1'b1, 32'h0, 1'b1}
   };

   // Zero width or height acts as one, oversized values act as the full grid.
   cfg_type fixed_settings [0:NUM_FIXED-1] = '{
      '{32'hFFFE_0000, 32'h0003_0000, 32'h0001_8000, 32'h0000_8000, 9'd5, 9'd4},
      '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 9'd0, 9'd511},
      '{32'h0000_0000, 32'h0000_0000, 32'h0010_0000, 32'h0002_0000, 9'd256, 9'd2},
      '{32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 32'h0001_0000, 9'd2, 9'd2},
      '{32'h0000_8000, 32'hFFFF_8000, 32'h0001_0000, 32'h0001_0000, 9'd1, 9'd1}
   };
   int fixed_counts [0:NUM_FIXED-1] = '{70, 20, 70, 60, 20};

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("heightmap_bilinear_sampler test failed");
         $finish;
      end
   end

   function automatic longint unsigned eff_dim(input logic [8:0] v);
      if (v == 0)
         return 1;
      if (v > MAX_DIM)
         return MAX_DIM;
      return longint'(v);
   endfunction

   // World coordinate to cell index and fraction; fails below the origin.
   function automatic bit locate(input logic [31:0] pos, input logic [31:0] origin,
                                 input logic [31:0] scale, output longint unsigned index,
                                 output logic [FRAC_BITS-1:0] frac);
      longint      offset;
      logic [63:0] offset_u;
      logic [63:0] prod;
      offset = longint'($signed(pos)) - longint'($signed(origin));
      index  = 0;
      frac   = '0;
      if (offset < 0)
         return 1'b0;
      offset_u = offset;
      prod     = offset_u * {32'h0, scale};
      index    = prod >> (2 * FRAC_BITS);
      frac     = prod[2*FRAC_BITS-1 -: FRAC_BITS];
      return 1'b1;
   endfunction

   function automatic longint blend(input longint a, input longint b,
                                    input logic [FRAC_BITS-1:0] t);
      longint prod;
      prod = (b - a) * longint'({1'b0, t});
      return a + (prod >>> FRAC_BITS);
   endfunction

   function automatic longint stored_height(input longint unsigned col,
                                            input longint unsigned row,
                                            input longint unsigned width);
      return longint'($signed(store_copy[row * width + col]));
   endfunction

   function automatic height_answer_type heightmap_answer(input stim_row_type word);
      longint unsigned        col;
      longint unsigned        row;
      longint unsigned        width;
      longint unsigned        depth;
      logic [FRAC_BITS-1:0]   tx;
      logic [FRAC_BITS-1:0]   tz;
      bit                     ok;
      longint                 result;
      height_answer_type      answer;
      width  = eff_dim(grid_now.width);
      depth  = eff_dim(grid_now.height);
      col    = word.col;
      row    = word.row;
      tx     = '0;
      tz     = '0;
      ok     = 1'b1;
      result = 0;
      if (word.op == OP_WRITE_POS || word.op == OP_SAMPLE)
         ok = locate(word.pos_x, grid_now.origin_x, grid_now.cpu_x, col, tx) &&
              locate(word.pos_z, grid_now.origin_z, grid_now.cpu_z, row, tz);
      ok = ok && col < width && row < depth;
      if (word.op == OP_SAMPLE)
         ok = ok && col + 1 < width && row + 1 < depth;
      if (ok) begin
         case (word.op)
            OP_WRITE_CELL, OP_WRITE_POS: begin
               store_copy[row * width + col]  = word.value;
               written_map[row * width + col] = 1'b1;
            end
            OP_READ_CELL: result = stored_height(col, row, width);
            default: begin
               result = blend(blend(stored_height(col, row, width),
                                    stored_height(col + 1, row, width), tx),
                              blend(stored_height(col, row + 1, width),
                                    stored_height(col + 1, row + 1, width), tx), tz);
            end
         endcase
      end
      answer.height   = result[31:0];
      answer.in_range = ok;
      return answer;
   endfunction

   function automatic int pick_index(input longint unsigned dim);
      int roll;
      int top;
      roll = $urandom_range(99);
      top  = int'(dim);
      if (roll < 70)
         return $urandom_range(0, (top - 1 < 7) ? top - 1 : 7);
      if (roll < 90)
         return $urandom_range((top >= 2) ? top - 2 : 0, (top > 255) ? 255 : top);
      return $urandom_range(0, 255);
   endfunction

   // Aim a world coordinate at a chosen cell; falls back to noise when it cannot be reached.
   function automatic logic [31:0] aim_position(input logic [31:0] origin,
                                                input logic [31:0] scale,
                                                input longint unsigned dim);
      logic [63:0] target;
      logic [63:0] offset;
      longint      pos;
      target = {32'(pick_index(dim)), 32'($urandom)};
      if (scale == 0)
         offset = 64'($urandom_range(0, 1 << 20));
      else
         offset = target / {32'h0, scale};
      pos = longint'($signed(origin)) + longint'(offset);
      if (offset > 64'hFFFF_FFFF || pos > 64'sd2147483647)
         return $urandom;
      return pos[31:0];
   endfunction

   function automatic logic [31:0] pick_origin();
      if ($urandom_range(3) == 0)
         return $urandom;
      return 32'($urandom_range(0, 1 << 22)) - 32'h0020_0000;
   endfunction

   function automatic logic [31:0] pick_scale();
      if ($urandom_range(3) == 0)
         return $urandom;
      return 32'($urandom_range(32'h4000, 32'h40000));
   endfunction

   task automatic send_word(input stim_row_type word);
      height_answer_type answer;
      if (!calm_stretch && $urandom_range(99) < 16) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= word.op;
      req_tdata  <= {word.value, word.row, word.col, word.pos_z, word.pos_x};
      do @(posedge clock); while (!req_tready);
      answer = heightmap_answer(word);
      if (word.typed) begin
         answer.height   = word.want_height;
         answer.in_range = word.want_range;
      end
      pending_heights.push_back(answer);
      op_count[word.op]++;
      if (word.op == OP_SAMPLE && answer.in_range)
         sample_hits++;
   endtask

   task automatic send_random_word();
      stim_row_type           word;
      longint unsigned        width;
      longint unsigned        depth;
      longint unsigned        col;
      longint unsigned        row;
      logic [FRAC_BITS-1:0]   tx;
      logic [FRAC_BITS-1:0]   tz;
      int                     roll;
      bit                     found;
      width      = eff_dim(grid_now.width);
      depth      = eff_dim(grid_now.height);
      word       = '0;
      word.op    = 2'($urandom_range(0, 3));
      word.pos_x = $urandom;
      word.pos_z = $urandom;
      word.col   = 8'($urandom);
      word.row   = 8'($urandom);
      word.value = $urandom;
      roll       = $urandom_range(99);
      if (roll >= 12) begin
         if (roll < 17)
            word.pos_x = grid_now.origin_x - 32'($urandom_range(1, 1 << 18));
         else
            word.pos_x = aim_position(grid_now.origin_x, grid_now.cpu_x, width);
         word.pos_z = aim_position(grid_now.origin_z, grid_now.cpu_z, depth);
         word.col   = 8'(pick_index(width));
         word.row   = 8'(pick_index(depth));
         if ($urandom_range(3) == 0)
            word.value = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      end
      // A cell is never read before it has been written: such a word becomes the write.
      if (word.op == OP_READ_CELL && word.col < width && word.row < depth &&
          !written_map[word.row * width + word.col])
         word.op = OP_WRITE_CELL;
      if (word.op == OP_SAMPLE &&
          locate(word.pos_x, grid_now.origin_x, grid_now.cpu_x, col, tx) &&
          locate(word.pos_z, grid_now.origin_z, grid_now.cpu_z, row, tz) &&
          col + 1 < width && row + 1 < depth) begin
         found = 1'b0;
         for (int k = 0; k < 4; k++) begin
            if (!found && !written_map[(row + k / 2) * width + col + k % 2]) begin
               found    = 1'b1;
               word.op  = OP_WRITE_CELL;
               word.col = 8'(col + k % 2);
               word.row = 8'(row + k / 2);
            end
         end
      end
      send_word(word);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_heights.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_reg(input int index, input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= 5'(index * 4);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (index)
         REG_ORIGIN_X:    grid_now.origin_x = value;
         REG_ORIGIN_Z:    grid_now.origin_z = value;
         REG_CELLS_X:     grid_now.cpu_x    = value;
         REG_CELLS_Z:     grid_now.cpu_z    = value;
         REG_GRID_WIDTH:  grid_now.width    = value[8:0];
         REG_GRID_HEIGHT: grid_now.height   = value[8:0];
         default: ;
      endcase
   endtask

   task automatic apply_setting(input cfg_type setting);
      drain_results();
      write_reg(REG_ORIGIN_X, setting.origin_x);
      write_reg(REG_ORIGIN_Z, setting.origin_z);
      write_reg(REG_CELLS_X, setting.cpu_x);
      write_reg(REG_CELLS_Z, setting.cpu_z);
      write_reg(REG_GRID_WIDTH, 32'(setting.width));
      write_reg(REG_GRID_HEIGHT, 32'(setting.height));
      settings_count++;
   endtask

   always @(posedge clock) begin
      rsp_tready <= calm_stretch || ($urandom_range(99) >= 16);
   end

   always @(posedge clock) begin
      height_answer_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         checked_count++;
         if (pending_heights.size() == 0) begin
            $error("unexpected result word: height_out %h in_range %b", rsp_tdata, rsp_tuser);
            mismatch_count++;
         end else begin
            want = pending_heights.pop_front();
            if (rsp_tdata !== want.height) begin
               $error("height_out: expected %h, got %h", want.height, rsp_tdata);
               mismatch_count++;
            end
            if (rsp_tuser[0] !== want.in_range) begin
               $error("in_range: expected %b, got %b", want.in_range, rsp_tuser[0]);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      cfg_type random_grid;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_DIRECTED; i++)
         send_word(directed_rows[i]);

      for (int p = 0; p < NUM_FIXED; p++) begin
         calm_stretch <= (p == 2);
         apply_setting(fixed_settings[p]);
         repeat (fixed_counts[p]) send_random_word();
      end
      calm_stretch <= 1'b0;

      for (int p = 0; p < NUM_RANDOM_GRID; p++) begin
         random_grid.origin_x = pick_origin();
         random_grid.origin_z = pick_origin();
         random_grid.cpu_x    = pick_scale();
         random_grid.cpu_z    = pick_scale();
         random_grid.width    = 9'($urandom_range(0, 5) == 0 ? $urandom_range(200, 256)
                                                            : $urandom_range(2, 12));
         random_grid.height   = 9'($urandom_range(2, 12));
         apply_setting(random_grid);
         repeat (52) send_random_word();
      end

      drain_results();
      repeat (40) @(posedge clock);

      $display("Sent %0d cell writes, %0d cell reads, %0d position writes and %0d samples",
               op_count[OP_WRITE_CELL], op_count[OP_READ_CELL], op_count[OP_WRITE_POS],
               op_count[OP_SAMPLE]);
      $display("%0d samples landed inside the grid; %0d grid settings; %0d results checked",
               sample_hits, settings_count, checked_count);
      if (mismatch_count == 0)
         $display("heightmap_bilinear_sampler test passed");
      else
         $display("heightmap_bilinear_sampler test failed");
      $finish;
   end

endmodule

// ===== heightmap_bilinear_sampler.f =====
hdl/hbs_pkg.sv
hdl/hbs_front.sv
hdl/hbs_queue.sv
hdl/hbs_back.sv
hdl/heightmap_bilinear_sampler.sv
dv/tb_heightmap_bilinear_sampler.sv
